@@ sv/sip_pkg.sv @@
`default_nettype none
package sip_pkg;

	typedef logic [63:0] word_t;
	typedef word_t [3:0] chain_t;

	// configuration register indices
	typedef enum logic {
		CFG_KEY_LOW  = 1'b0,
		CFG_KEY_HIGH = 1'b1
	} cfg_reg_t;

	localparam word_t KEY_LOW_RST  = 64'ha6592ea25e04ac3c;
	localparam word_t KEY_HIGH_RST = 64'hba3cba04ed28a9ae;

	localparam word_t SIP_C0 = 64'h736f6d6570736575;
	localparam word_t SIP_C1 = 64'h646f72616e646f6d;
	localparam word_t SIP_C2 = 64'h6c7967656e657261;
	localparam word_t SIP_C3 = 64'h7465646279746573;

	localparam word_t FIN_XOR = 64'h00000000000000ff;

	localparam int unsigned LEN_SHIFT = 56;

endpackage
`default_nettype wire

@@ sv/sip_round.sv @@
`default_nettype none
// One SipRound, purely combinational.
module sip_round (
	input  wire sip_pkg::chain_t chain_in,
	output sip_pkg::chain_t      chain_out
);
	import sip_pkg::*;

	function automatic word_t rotl(input word_t x, input int unsigned n);
		return (x << n) | (x >> (64 - n));
	endfunction

	word_t a0, b0, c0, d0;
	word_t a1, b1, c1, d1;
	word_t a2, d2;
	word_t a3, d3;
	word_t b4, c4;

	always_comb begin
		a0 = chain_in[0] + chain_in[1];
		b0 = rotl(chain_in[1], 13) ^ a0;
		a1 = rotl(a0, 32);
		c0 = chain_in[2] + chain_in[3];
		d0 = rotl(chain_in[3], 16) ^ c0;
		a2 = a1 + d0;
		d2 = rotl(d0, 21) ^ a2;
		c1 = c0 + b0;
		b1 = rotl(b0, 17) ^ c1;
		c4 = rotl(c1, 32);
		a3 = a2;
		d3 = d2;
		b4 = b1;
		d1 = d3;
		chain_out[0] = a3;
		chain_out[1] = b4;
		chain_out[2] = c4;
		chain_out[3] = d1;
	end

endmodule
`default_nettype wire

@@ sv/siphash_2_4_hasher_unit.sv @@
`default_nettype none
// SipHash-2-4 over a stream of little-endian 64-bit words, one SipRound unit
// shared by every round. A full word takes two rounds, and the next word is
// taken in the last of them. A last item with 0..7 bytes takes 2 rounds for
// the tail block, 4 finalisation rounds and a step to fold the digest into
// the output register, after which the unit is idle and takes the next
// item; a last item with 8 bytes adds 2 rounds for the full word. The digest
// sits in its own output register, so the next message may start while a
// hash still waits to be taken; a digest only stalls the unit if the
// previous one is still held at the moment it is ready. Key registers are
// written through the cfg port (index 0 key low, index 1 key high) and take
// effect at the next message start; write them only while the unit is idle.
module siphash_2_4_hasher_unit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// configuration write channel
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire sip_pkg::cfg_reg_t cfg_index,
	input  wire sip_pkg::word_t   cfg_data,
	// message channel
	input  wire logic             msg_valid,
	output logic                  msg_stall,
	input  wire sip_pkg::word_t   message_word,
	input  wire logic [3:0]       byte_count,
	input  wire logic             last_word,
	// digest channel
	output logic                  hash_valid,
	input  wire logic             hash_stall,
	output sip_pkg::word_t        hash_value
);
	import sip_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COMP = 4'b0010,
		ST_FIN  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t      state_q;
	logic [1:0]  rnd_q;
	logic        inside_q;      // mid-message: chain already keyed
	logic        is_tail_q;     // block in flight is the final (length) block
	logic        need_tail_q;   // full last word: empty tail block follows
	logic [7:0]  len_q;         // byte tally mod 256
	word_t       key_low_q;
	word_t       key_high_q;
	chain_t      chain_q;
	word_t       m_q;           // block being compressed
	word_t       tail_q;        // queued tail block
	word_t       hash_q;
	logic        hash_valid_q;

	chain_t      chain_rnd;
	chain_t      chain_done;
	chain_t      chain_key;
	chain_t      chain_start;
	logic [3:0]  cnt_sat;
	logic        full_in;
	logic [7:0]  len_total;
	word_t       tail_word;
	word_t       tail_block;
	word_t       first_block;
	logic        accept;
	logic        comp_end;
	logic        free_end;
	logic        out_free;

	sip_round u_round (
		.chain_in  (chain_q),
		.chain_out (chain_rnd)
	);

	assign cfg_ready  = 1'b1;
	assign hash_valid = hash_valid_q;
	assign hash_value = hash_q;

	assign comp_end = (state_q == ST_COMP) && (rnd_q == 2'd1);
	// plain full word finishing: next word may enter this cycle
	assign free_end = comp_end && !is_tail_q && !need_tail_q;
	assign msg_stall = !((state_q == ST_IDLE) || free_end);
	assign accept = msg_valid && !msg_stall;
	assign out_free = !hash_valid_q || !hash_stall;

	always_comb begin
		// end of compression: fold the block back into v0
		chain_done    = chain_rnd;
		chain_done[0] = chain_rnd[0] ^ m_q;

		chain_key[0] = key_low_q  ^ SIP_C0;
		chain_key[1] = key_high_q ^ SIP_C1;
		chain_key[2] = key_low_q  ^ SIP_C2;
		chain_key[3] = key_high_q ^ SIP_C3;

		// non-last words count as 8 bytes; oversize counts saturate
		if (!last_word || byte_count[3])
			cnt_sat = 4'd8;
		else
			cnt_sat = byte_count;
		full_in   = cnt_sat[3];
		len_total = (inside_q ? len_q : 8'd0) + {4'd0, cnt_sat};

		for (int i = 0; i < 8; i++) begin
			if (!full_in && (4'(i) < cnt_sat))
				tail_word[8*i +: 8] = message_word[8*i +: 8];
			else
				tail_word[8*i +: 8] = 8'd0;
		end
		tail_block  = ({56'd0, len_total} << LEN_SHIFT) | tail_word;
		first_block = full_in ? message_word : tail_block;

		if (!inside_q)
			chain_start = chain_key;
		else if (state_q == ST_IDLE)
			chain_start = chain_q;
		else
			chain_start = chain_done;
		chain_start[3] = chain_start[3] ^ first_block;
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			rnd_q        <= 2'd0;
			inside_q     <= 1'b0;
			is_tail_q    <= 1'b0;
			need_tail_q  <= 1'b0;
			len_q        <= 8'd0;
			key_low_q    <= KEY_LOW_RST;
			key_high_q   <= KEY_HIGH_RST;
			hash_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_KEY_LOW:  key_low_q  <= cfg_data;
					CFG_KEY_HIGH: key_high_q <= cfg_data;
					default: ;
				endcase
			end

			// new digest loads as the old one leaves
			if ((state_q == ST_DONE) && out_free)
				hash_valid_q <= 1'b1;
			else if (hash_valid_q && !hash_stall)
				hash_valid_q <= 1'b0;

			if (accept) begin
				state_q     <= ST_COMP;
				rnd_q       <= 2'd0;
				is_tail_q   <= !full_in;
				need_tail_q <= last_word && full_in;
				len_q       <= last_word ? 8'd0 : len_total;
				inside_q    <= !last_word;
			end else begin
				unique case (state_q)
					ST_IDLE: ;
					ST_COMP: begin
						if (comp_end) begin
							rnd_q <= 2'd0;
							if (is_tail_q)
								state_q <= ST_FIN;
							else if (need_tail_q) begin
								is_tail_q   <= 1'b1;
								need_tail_q <= 1'b0;
							end else
								state_q <= ST_IDLE;
						end else
							rnd_q <= rnd_q + 2'd1;
					end
					ST_FIN: begin
						rnd_q <= rnd_q + 2'd1;
						if (rnd_q == 2'd3)
							state_q <= ST_DONE;
					end
					ST_DONE: begin
						if (out_free)
							state_q <= ST_IDLE;
					end
					default: state_q <= ST_IDLE;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (accept) begin
			chain_q <= chain_start;
			m_q     <= first_block;
			tail_q  <= tail_block;
		end else begin
			unique case (state_q)
				ST_IDLE: ;
				ST_COMP: begin
					if (!comp_end)
						chain_q <= chain_rnd;
					else if (is_tail_q)
						chain_q <= {chain_done[3], chain_done[2] ^ FIN_XOR,
							chain_done[1], chain_done[0]};
					else if (need_tail_q) begin
						chain_q <= {chain_done[3] ^ tail_q, chain_done[2],
							chain_done[1], chain_done[0]};
						m_q     <= tail_q;
					end else
						chain_q <= chain_done;
				end
				ST_FIN: chain_q <= chain_rnd;
				ST_DONE: begin
					if (out_free)
						hash_q <= chain_q[0] ^ chain_q[1] ^ chain_q[2] ^ chain_q[3];
				end
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire
